FILE: hdl/sbl_pkg.sv
`timescale 1ns / 1ps

package sbl_pkg;

    // lexer modes
    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_ZERO  = 3'd1;
    localparam logic [2:0] M_ZEROX = 3'd2;
    localparam logic [2:0] M_DEC   = 3'd3;
    localparam logic [2:0] M_OCT   = 3'd4;
    localparam logic [2:0] M_HEX   = 3'd5;
    localparam logic [2:0] M_IDENT = 3'd6;
    localparam logic [2:0] M_SKIP  = 3'd7;

    // token kinds
    localparam logic [2:0] K_LPAREN = 3'd0;
    localparam logic [2:0] K_RPAREN = 3'd1;
    localparam logic [2:0] K_NUMBER = 3'd2;
    localparam logic [2:0] K_IDENT  = 3'd3;
    localparam logic [2:0] K_END    = 3'd4;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_UC_X   = 8'h58;

    // digit value that means "not a digit"
    localparam logic [4:0] NO_DIGIT = 5'd16;

    localparam logic [4:0] BASE_DEC = 5'd10;
    localparam logic [4:0] BASE_OCT = 5'd8;
    localparam logic [4:0] BASE_HEX = 5'd16;

    localparam int NUM_W = 63;
    localparam int RES_DEPTH = 3;

    typedef struct packed {
        logic [2:0]       kind;
        logic [NUM_W-1:0] number_value;
        logic [7:0]       ident_char;
        logic             ident_end;
    } result_t;

    typedef struct packed {
        logic                  load;
        logic [1:0]            count;
        result_t [RES_DEPTH-1:0] res;
    } lex_out_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return is_ws(c) || c == CH_LPAREN || c == CH_RPAREN || c == CH_NUL;
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            t = c - CH_ZERO;
            return t[4:0];
        end
        if (c >= CH_LC_A && c <= CH_LC_F)
        begin
            t = c - CH_LC_A + 8'd10;
            return t[4:0];
        end
        if (c >= CH_UC_A && c <= CH_UC_F)
        begin
            t = c - CH_UC_A + 8'd10;
            return t[4:0];
        end
        return NO_DIGIT;
    endfunction

    function automatic result_t make_res(input logic [2:0] kind,
                                         input logic [NUM_W-1:0] num,
                                         input logic [7:0] ch,
                                         input logic fin);
        result_t r;
        r.kind         = kind;
        r.number_value = num;
        r.ident_char   = ch;
        r.ident_end    = fin;
        return r;
    endfunction

endpackage

FILE: hdl/sbl_byte_if.sv
`timescale 1ns / 1ps

interface sbl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

FILE: hdl/sbl_token_if.sv
`timescale 1ns / 1ps

interface sbl_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [62:0] number_value;
    logic [7:0]  ident_char;
    logic        ident_end;
    logic        last;

    modport source (output valid, output kind, output number_value, output ident_char,
                    output ident_end, output last, input ready);
    modport sink (input valid, input kind, input number_value, input ident_char,
                  input ident_end, input last, output ready);
endinterface

FILE: hdl/sbl_lexer.sv
`timescale 1ns / 1ps

module sbl_lexer
(
    input  logic                clk,
    input  logic                rst_n,
    sbl_byte_if.sink            byte_chan,
    input  logic                load_ok,
    output sbl_pkg::lex_out_t   lex_out
);

    logic                     ivalid_reg;
    logic [7:0]               ibyte_reg;
    logic                     ieoi_reg;
    logic                     advance;

    logic [2:0]               mode_reg, mode_next;
    logic [sbl_pkg::NUM_W-1:0] acc_reg, acc_next;
    logic                     ovf_reg, ovf_next;
    logic [7:0]               held_reg, held_next;
    logic                     ended_reg, ended_next;

    sbl_pkg::result_t [sbl_pkg::RES_DEPTH-1:0] res;
    logic [1:0]               n;
    logic                     do_start;
    logic [4:0]               digit;
    logic [4:0]               base;
    logic [67:0]              acc_x;
    logic [67:0]              sum;
    logic [sbl_pkg::NUM_W-1:0] num_val;
    logic [sbl_pkg::NUM_W-1:0] digit_num;

    assign advance        = ivalid_reg && load_ok;
    assign byte_chan.ready = !ivalid_reg || load_ok;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivalid_reg <= 1'b0;
        end
        else if (byte_chan.ready)
        begin
            ivalid_reg <= byte_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_chan.ready && byte_chan.valid)
        begin
            ibyte_reg <= byte_chan.in_byte;
            ieoi_reg  <= byte_chan.end_of_input;
        end
    end

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= sbl_pkg::M_IDLE;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            held_reg  <= 8'd0;
            ended_reg <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            held_reg  <= held_next;
            ended_reg <= ended_next;
        end
    end

    // digit value and the next accumulator value
    always_comb
    begin
        digit     = sbl_pkg::hex_val(ibyte_reg);
        digit_num = {{(sbl_pkg::NUM_W-4){1'b0}}, digit[3:0]};
        case (mode_reg)
            sbl_pkg::M_DEC: base = sbl_pkg::BASE_DEC;
            sbl_pkg::M_OCT: base = sbl_pkg::BASE_OCT;
            default:        base = sbl_pkg::BASE_HEX;
        endcase
        acc_x = {5'd0, acc_reg};
        case (mode_reg)
            sbl_pkg::M_DEC: sum = (acc_x << 3) + (acc_x << 1);
            sbl_pkg::M_OCT: sum = acc_x << 3;
            default:        sum = acc_x << 4;
        endcase
        sum     = sum + {64'd0, digit[3:0]};
        num_val = ovf_reg ? {sbl_pkg::NUM_W{1'b1}} : acc_reg;
    end

    // one step of the lexer
    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        held_next  = held_reg;
        ended_next = ended_reg;
        res        = '0;
        n          = 2'd0;
        do_start   = 1'b0;

        if (!ended_reg)
        begin
            if (ieoi_reg)
            begin
                // flush any pending tokens, then the end token
                case (mode_reg)
                    sbl_pkg::M_ZERO, sbl_pkg::M_DEC, sbl_pkg::M_OCT, sbl_pkg::M_HEX:
                    begin
                        res[n] = sbl_pkg::make_res(sbl_pkg::K_NUMBER, num_val, 8'd0, 1'b0);
                        n      = n + 2'd1;
                    end
                    sbl_pkg::M_ZEROX:
                    begin
                        res[n] = sbl_pkg::make_res(sbl_pkg::K_NUMBER, '0, 8'd0, 1'b0);
                        n      = n + 2'd1;
                        res[n] = sbl_pkg::make_res(sbl_pkg::K_IDENT, '0, held_reg, 1'b1);
                        n      = n + 2'd1;
                    end
                    sbl_pkg::M_IDENT:
                    begin
                        res[n] = sbl_pkg::make_res(sbl_pkg::K_IDENT, '0, held_reg, 1'b1);
                        n      = n + 2'd1;
                    end
                    default:
                    begin
                    end
                endcase
                res[n]     = sbl_pkg::make_res(sbl_pkg::K_END, '0, 8'd0, 1'b0);
                n          = n + 2'd1;
                mode_next  = sbl_pkg::M_IDLE;
                acc_next   = '0;
                ovf_next   = 1'b0;
                held_next  = 8'd0;
                ended_next = 1'b1;
            end
            else
            begin
                case (mode_reg)
                    sbl_pkg::M_SKIP:
                    begin
                        if (ibyte_reg == sbl_pkg::CH_LF)
                        begin
                            mode_next = sbl_pkg::M_IDLE;
                        end
                    end
                    sbl_pkg::M_ZERO:
                    begin
                        if (ibyte_reg == sbl_pkg::CH_LC_X || ibyte_reg == sbl_pkg::CH_UC_X)
                        begin
                            held_next = ibyte_reg;
                            mode_next = sbl_pkg::M_ZEROX;
                        end
                        else if (ibyte_reg >= sbl_pkg::CH_ZERO &&
                                 ibyte_reg <= sbl_pkg::CH_SEVEN)
                        begin
                            mode_next = sbl_pkg::M_OCT;
                            acc_next  = digit_num;
                            ovf_next  = 1'b0;
                        end
                        else
                        begin
                            res[n]   = sbl_pkg::make_res(sbl_pkg::K_NUMBER, '0, 8'd0, 1'b0);
                            n        = n + 2'd1;
                            do_start = 1'b1;
                        end
                    end
                    sbl_pkg::M_ZEROX:
                    begin
                        if (digit != sbl_pkg::NO_DIGIT)
                        begin
                            held_next = 8'd0;
                            mode_next = sbl_pkg::M_HEX;
                            acc_next  = digit_num;
                            ovf_next  = 1'b0;
                        end
                        else
                        begin
                            // zero, then the x opens an identifier
                            res[n] = sbl_pkg::make_res(sbl_pkg::K_NUMBER, '0, 8'd0, 1'b0);
                            n      = n + 2'd1;
                            if (sbl_pkg::is_sep(ibyte_reg))
                            begin
                                res[n]    = sbl_pkg::make_res(sbl_pkg::K_IDENT, '0,
                                                              held_reg, 1'b1);
                                n         = n + 2'd1;
                                held_next = 8'd0;
                                do_start  = 1'b1;
                            end
                            else
                            begin
                                res[n]    = sbl_pkg::make_res(sbl_pkg::K_IDENT, '0,
                                                              held_reg, 1'b0);
                                n         = n + 2'd1;
                                held_next = ibyte_reg;
                                mode_next = sbl_pkg::M_IDENT;
                            end
                        end
                    end
                    sbl_pkg::M_DEC, sbl_pkg::M_OCT, sbl_pkg::M_HEX:
                    begin
                        if (digit < base)
                        begin
                            if (!ovf_reg)
                            begin
                                if (|sum[67:sbl_pkg::NUM_W])
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    acc_next = sum[sbl_pkg::NUM_W-1:0];
                                end
                            end
                        end
                        else
                        begin
                            res[n]   = sbl_pkg::make_res(sbl_pkg::K_NUMBER, num_val, 8'd0, 1'b0);
                            n        = n + 2'd1;
                            do_start = 1'b1;
                        end
                    end
                    sbl_pkg::M_IDENT:
                    begin
                        if (sbl_pkg::is_sep(ibyte_reg))
                        begin
                            res[n]    = sbl_pkg::make_res(sbl_pkg::K_IDENT, '0, held_reg, 1'b1);
                            n         = n + 2'd1;
                            held_next = 8'd0;
                            do_start  = 1'b1;
                        end
                        else
                        begin
                            res[n]    = sbl_pkg::make_res(sbl_pkg::K_IDENT, '0, held_reg, 1'b0);
                            n         = n + 2'd1;
                            held_next = ibyte_reg;
                        end
                    end
                    default:
                    begin
                        do_start = 1'b1;
                    end
                endcase

                // byte seen between tokens
                if (do_start)
                begin
                    mode_next = sbl_pkg::M_IDLE;
                    if (sbl_pkg::is_ws(ibyte_reg))
                    begin
                    end
                    else if (ibyte_reg == sbl_pkg::CH_LPAREN)
                    begin
                        res[n] = sbl_pkg::make_res(sbl_pkg::K_LPAREN, '0, 8'd0, 1'b0);
                        n      = n + 2'd1;
                    end
                    else if (ibyte_reg == sbl_pkg::CH_RPAREN)
                    begin
                        res[n] = sbl_pkg::make_res(sbl_pkg::K_RPAREN, '0, 8'd0, 1'b0);
                        n      = n + 2'd1;
                    end
                    else if (ibyte_reg == sbl_pkg::CH_NUL)
                    begin
                        mode_next = sbl_pkg::M_SKIP;
                    end
                    else if (ibyte_reg == sbl_pkg::CH_ZERO)
                    begin
                        mode_next = sbl_pkg::M_ZERO;
                        acc_next  = '0;
                        ovf_next  = 1'b0;
                    end
                    else if (ibyte_reg >= sbl_pkg::CH_ONE && ibyte_reg <= sbl_pkg::CH_NINE)
                    begin
                        mode_next = sbl_pkg::M_DEC;
                        acc_next  = digit_num;
                        ovf_next  = 1'b0;
                    end
                    else
                    begin
                        held_next = ibyte_reg;
                        mode_next = sbl_pkg::M_IDENT;
                    end
                end
            end
        end

        lex_out.load  = advance;
        lex_out.count = n;
        lex_out.res   = res;
    end

endmodule

FILE: hdl/sbl_outq.sv
`timescale 1ns / 1ps

module sbl_outq
(
    input  logic              clk,
    input  logic              rst_n,
    input  sbl_pkg::lex_out_t lex_out,
    output logic              load_ok,
    sbl_token_if.source       token_chan
);

    sbl_pkg::result_t [sbl_pkg::RES_DEPTH-1:0] q_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign pop     = token_chan.valid && token_chan.ready;
    assign load_ok = (count_reg == 2'd0) || (count_reg == 2'd1 && token_chan.ready);

    // result count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (lex_out.load)
        begin
            count_reg <= lex_out.count;
        end
        else if (pop)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    // result slots, head is slot 0
    always_ff @(posedge clk)
    begin
        if (lex_out.load)
        begin
            q_reg <= lex_out.res;
        end
        else if (pop)
        begin
            q_reg[0] <= q_reg[1];
            q_reg[1] <= q_reg[2];
        end
    end

    assign token_chan.valid        = count_reg != 2'd0;
    assign token_chan.kind         = q_reg[0].kind;
    assign token_chan.number_value = q_reg[0].number_value;
    assign token_chan.ident_char   = q_reg[0].ident_char;
    assign token_chan.ident_end    = q_reg[0].ident_end;
    assign token_chan.last         = count_reg == 2'd1;

endmodule

FILE: hdl/sexpr_byte_lexer_top.sv
`timescale 1ns / 1ps

// s-expression byte lexer
// byte_chan takes one text byte per request, or an end-of-input request
// whose byte is ignored; token_chan gives lparen, rparen, number, identifier
// byte and end tokens, with last set on the final token caused by a byte.
// a byte goes through an input register, then one lexer step, whose up to
// three tokens are loaded into the result slots together
// throughput: one byte per cycle while each byte gives at most one token
// and token_chan is ready; a byte that gives more tokens holds the slots
// until its last token is taken, since the token channel moves one token per cycle
// identifier bytes come out one byte late so the last one carries ident_end
// reset clears the lexer state and drops any queued tokens
// a stall on token_chan fills the slots and then the input register, after
// which byte_chan ready goes low; nothing is lost
// after the end token, further requests are taken and give no tokens
module sexpr_byte_lexer_top
(
    input  logic        clk,
    input  logic        rst_n,
    sbl_byte_if.sink    byte_chan,
    sbl_token_if.source token_chan
);

    sbl_pkg::lex_out_t lex_out;
    logic              load_ok;

    sbl_lexer u_lexer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_chan (byte_chan),
        .load_ok   (load_ok),
        .lex_out   (lex_out)
    );

    sbl_outq u_outq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .lex_out    (lex_out),
        .load_ok    (load_ok),
        .token_chan (token_chan)
    );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam logic [63:0] SAT_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          DRAIN_CYC = 64;

    // token numbering for the random text generator
    localparam int PICK_OPEN      = 0;
    localparam int PICK_CLOSE     = 1;
    localparam int PICK_DEC       = 2;
    localparam int PICK_OCT       = 3;
    localparam int PICK_HEX       = 4;
    localparam int PICK_ZERO_X    = 5;
    localparam int PICK_ZERO_89   = 6;
    localparam int PICK_WORD      = 7;
    localparam int PICK_SKIP_LINE = 8;
    localparam int PICK_SKIP_OPEN = 9;
    localparam int PICK_NOISE     = 10;

    typedef struct packed {
        logic [2:0]  kind;
        logic [62:0] number_value;
        logic [7:0]  ident_char;
        logic        ident_end;
        logic        last;
    } token_t;

    typedef struct {
        logic [7:0] b;
        bit         typed;
        token_t     want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sbl_byte_if  byte_chan ();
    sbl_token_if token_chan ();

    sexpr_byte_lexer_top dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_chan  (byte_chan),
        .token_chan (token_chan)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // lexer shadow state
    logic [2:0]  lx_mode;
    logic [63:0] lx_acc;
    logic        lx_ovf;
    logic [7:0]  lx_held;
    logic        lx_seen_end;

    token_t step_tokens[$];
    token_t pending_tokens[$];
    row_t   dir_rows[$];

    int          errors = 0;
    int unsigned items_sent = 0;
    bit          src_calm = 1'b0;
    bit          snk_calm = 1'b0;

    // character classes
    function automatic bit ws_byte(logic [7:0] c);
        return c == sbl_pkg::CH_SPACE || (c >= sbl_pkg::CH_TAB && c <= sbl_pkg::CH_CR);
    endfunction

    function automatic bit sep_byte(logic [7:0] c);
        return ws_byte(c) || c == sbl_pkg::CH_LPAREN || c == sbl_pkg::CH_RPAREN ||
               c == sbl_pkg::CH_NUL;
    endfunction

    function automatic logic [4:0] digit_of(logic [7:0] c);
        if (c >= sbl_pkg::CH_ZERO && c <= sbl_pkg::CH_NINE)
            return 5'(c - sbl_pkg::CH_ZERO);
        if (c >= sbl_pkg::CH_LC_A && c <= sbl_pkg::CH_LC_F)
            return 5'(c - sbl_pkg::CH_LC_A + 8'd10);
        if (c >= sbl_pkg::CH_UC_A && c <= sbl_pkg::CH_UC_F)
            return 5'(c - sbl_pkg::CH_UC_A + 8'd10);
        return sbl_pkg::NO_DIGIT;
    endfunction

    function automatic void emit(logic [2:0] k, logic [62:0] v, logic [7:0] c, logic f);
        token_t t;
        t.kind         = k;
        t.number_value = v;
        t.ident_char   = c;
        t.ident_end    = f;
        t.last         = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void num_begin(logic [2:0] m, logic [4:0] d);
        lx_mode = m;
        lx_acc  = 64'(d);
        lx_ovf  = 1'b0;
    endfunction

    function automatic void num_token();
        emit(sbl_pkg::K_NUMBER, lx_ovf ? SAT_MAX[62:0] : lx_acc[62:0], 8'd0, 1'b0);
    endfunction

    // saturating multiply-add of one digit
    function automatic void accumulate(logic [4:0] base, logic [4:0] d);
        if (lx_ovf)
            return;
        if (lx_acc > (SAT_MAX - 64'(d)) / 64'(base))
            lx_ovf = 1'b1;
        else
            lx_acc = lx_acc * 64'(base) + 64'(d);
    endfunction

    // byte seen between tokens
    function automatic void lex_start(logic [7:0] c);
        lx_mode = sbl_pkg::M_IDLE;
        if (ws_byte(c))
            return;
        if (c == sbl_pkg::CH_LPAREN)
            emit(sbl_pkg::K_LPAREN, 63'd0, 8'd0, 1'b0);
        else if (c == sbl_pkg::CH_RPAREN)
            emit(sbl_pkg::K_RPAREN, 63'd0, 8'd0, 1'b0);
        else if (c == sbl_pkg::CH_NUL)
            lx_mode = sbl_pkg::M_SKIP;
        else if (c == sbl_pkg::CH_ZERO)
            num_begin(sbl_pkg::M_ZERO, 5'd0);
        else if (c >= sbl_pkg::CH_ONE && c <= sbl_pkg::CH_NINE)
            num_begin(sbl_pkg::M_DEC, 5'(c - sbl_pkg::CH_ZERO));
        else
        begin
            lx_held = c;
            lx_mode = sbl_pkg::M_IDENT;
        end
    endfunction

    // byte seen while an identifier byte is held back
    function automatic void lex_ident(logic [7:0] c);
        if (sep_byte(c))
        begin
            emit(sbl_pkg::K_IDENT, 63'd0, lx_held, 1'b1);
            lx_held = 8'd0;
            lex_start(c);
        end
        else
        begin
            emit(sbl_pkg::K_IDENT, 63'd0, lx_held, 1'b0);
            lx_held = c;
        end
    endfunction

    // one accepted request: fills step_tokens with the tokens it causes
    function automatic void lex_step(logic [7:0] c, logic eoi);
        logic [4:0] d;
        logic [4:0] base;
        step_tokens.delete();
        if (lx_seen_end)
            return;
        if (eoi)
        begin
            case (lx_mode)
                sbl_pkg::M_ZERO, sbl_pkg::M_DEC, sbl_pkg::M_OCT, sbl_pkg::M_HEX:
                    num_token();
                sbl_pkg::M_ZEROX:
                begin
                    emit(sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
                    emit(sbl_pkg::K_IDENT, 63'd0, lx_held, 1'b1);
                end
                sbl_pkg::M_IDENT:
                    emit(sbl_pkg::K_IDENT, 63'd0, lx_held, 1'b1);
                default:
                    ;
            endcase
            emit(sbl_pkg::K_END, 63'd0, 8'd0, 1'b0);
            lx_mode     = sbl_pkg::M_IDLE;
            lx_acc      = 64'd0;
            lx_ovf      = 1'b0;
            lx_held     = 8'd0;
            lx_seen_end = 1'b1;
            return;
        end
        case (lx_mode)
            sbl_pkg::M_SKIP:
            begin
                if (c == sbl_pkg::CH_LF)
                    lx_mode = sbl_pkg::M_IDLE;
            end
            sbl_pkg::M_ZERO:
            begin
                if (c == sbl_pkg::CH_LC_X || c == sbl_pkg::CH_UC_X)
                begin
                    lx_held = c;
                    lx_mode = sbl_pkg::M_ZEROX;
                end
                else if (c >= sbl_pkg::CH_ZERO && c <= sbl_pkg::CH_SEVEN)
                    num_begin(sbl_pkg::M_OCT, 5'(c - sbl_pkg::CH_ZERO));
                else
                begin
                    emit(sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
                    lex_start(c);
                end
            end
            sbl_pkg::M_ZEROX:
            begin
                d = digit_of(c);
                if (d < sbl_pkg::BASE_HEX)
                begin
                    lx_held = 8'd0;
                    num_begin(sbl_pkg::M_HEX, d);
                end
                else
                begin
                    emit(sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
                    lx_mode = sbl_pkg::M_IDENT;
                    lex_ident(c);
                end
            end
            sbl_pkg::M_DEC, sbl_pkg::M_OCT, sbl_pkg::M_HEX:
            begin
                d    = digit_of(c);
                base = (lx_mode == sbl_pkg::M_DEC) ? sbl_pkg::BASE_DEC :
                       (lx_mode == sbl_pkg::M_OCT) ? sbl_pkg::BASE_OCT : sbl_pkg::BASE_HEX;
                if (d < base)
                    accumulate(base, d);
                else
                begin
                    num_token();
                    lex_start(c);
                end
            end
            sbl_pkg::M_IDENT:
                lex_ident(c);
            default:
                lex_start(c);
        endcase
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void dir_row(logic [7:0] b, bit typed, logic [2:0] k,
                                    logic [62:0] v, logic [7:0] c, logic f);
        row_t r;
        r.b    = b;
        r.typed = typed;
        r.want = '{kind: k, number_value: v, ident_char: c, ident_end: f, last: 1'b1};
        dir_rows.push_back(r);
    endfunction

    function automatic logic [7:0] rand_ws();
        int unsigned r;
        r = $urandom_range(0, 5);
        return (r == 5) ? sbl_pkg::CH_SPACE : sbl_pkg::CH_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] rand_digit(int unsigned base);
        int unsigned d;
        d = $urandom_range(0, base - 1);
        if (d < 10)
            return sbl_pkg::CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? sbl_pkg::CH_UC_A : sbl_pkg::CH_LC_A) + 8'(d - 10);
    endfunction

    function automatic logic [7:0] rand_ident_byte(bit first);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (sep_byte(c) || (first && c >= sbl_pkg::CH_ZERO && c <= sbl_pkg::CH_NINE));
        return c;
    endfunction

    // drive one request, then predict its tokens once it is taken
    task automatic send_item(input logic [7:0] b, input logic eoi, input bit typed,
                             input token_t want);
        int unsigned gap;
        token_t      t;
        gap = src_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            byte_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_chan.valid        <= 1'b1;
        byte_chan.in_byte      <= b;
        byte_chan.end_of_input <= eoi;
        @(posedge clk);
        while (!byte_chan.ready)
            @(posedge clk);
        lex_step(b, eoi);
        if (typed)
        begin
            step_tokens.delete();
            step_tokens.push_back(want);
        end
        foreach (step_tokens[i])
        begin
            t      = step_tokens[i];
            t.last = (i == step_tokens.size() - 1);
            pending_tokens.push_back(t);
        end
        items_sent++;
        if ($urandom_range(0, 29) == 0)
            src_calm = !src_calm;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(b, 1'b0, 1'b0, '0);
    endtask

    // one token of random content, no trailing separator
    task automatic send_token(input int pick);
        int unsigned len;
        logic [7:0]  c;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 5);
        case (pick)
            PICK_OPEN:
                send_byte(sbl_pkg::CH_LPAREN);
            PICK_CLOSE:
                send_byte(sbl_pkg::CH_RPAREN);
            PICK_DEC:
            begin
                send_byte(sbl_pkg::CH_ONE + 8'($urandom_range(0, 8)));
                repeat (len - 1) send_byte(rand_digit(10));
            end
            PICK_OCT:
            begin
                send_byte(sbl_pkg::CH_ZERO);
                repeat (len - 1) send_byte(rand_digit(8));
            end
            PICK_HEX:
            begin
                send_byte(sbl_pkg::CH_ZERO);
                send_byte($urandom_range(0, 1) ? sbl_pkg::CH_UC_X : sbl_pkg::CH_LC_X);
                repeat (len) send_byte(rand_digit(16));
            end
            PICK_ZERO_X:
            begin
                send_byte(sbl_pkg::CH_ZERO);
                send_byte($urandom_range(0, 1) ? sbl_pkg::CH_UC_X : sbl_pkg::CH_LC_X);
            end
            PICK_ZERO_89:
            begin
                send_byte(sbl_pkg::CH_ZERO);
                send_byte(sbl_pkg::CH_NINE - 8'($urandom_range(0, 1)));
            end
            PICK_WORD:
            begin
                send_byte(rand_ident_byte(1'b1));
                repeat ($urandom_range(0, 5)) send_byte(rand_ident_byte(1'b0));
            end
            PICK_SKIP_LINE:
            begin
                send_byte(sbl_pkg::CH_NUL);
                repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
                send_byte(sbl_pkg::CH_LF);
            end
            PICK_SKIP_OPEN:
            begin
                send_byte(sbl_pkg::CH_NUL);
                repeat ($urandom_range(0, 3))
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == sbl_pkg::CH_LF);
                    send_byte(c);
                end
            end
            default:
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    // stimulus
    initial
    begin : stim
        int pick;
        lx_mode                = sbl_pkg::M_IDLE;
        lx_acc                 = 64'd0;
        lx_ovf                 = 1'b0;
        lx_held                = 8'd0;
        lx_seen_end            = 1'b0;
        byte_chan.valid        = 1'b0;
        byte_chan.in_byte      = 8'd0;
        byte_chan.end_of_input = 1'b0;

        // directed text; typed rows hold the single token they must give
        dir_row(sbl_pkg::CH_LPAREN, 1'b1, sbl_pkg::K_LPAREN, 63'd0, 8'd0, 1'b0);
        dir_row(sbl_pkg::CH_RPAREN, 1'b1, sbl_pkg::K_RPAREN, 63'd0, 8'd0, 1'b0);
        dir_row(8'hFF,              1'b0, sbl_pkg::K_IDENT, 63'd0, 8'd0, 1'b0);
        dir_row(sbl_pkg::CH_SPACE,  1'b1, sbl_pkg::K_IDENT, 63'd0, 8'hFF, 1'b1);
        // zero then x with no hex digit
        dir_row(sbl_pkg::CH_ZERO,   1'b0, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
        dir_row(sbl_pkg::CH_LC_X,   1'b0, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
        dir_row(sbl_pkg::CH_LPAREN, 1'b0, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
        // zero then nine
        dir_row(sbl_pkg::CH_ZERO,   1'b0, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
        dir_row(sbl_pkg::CH_NINE,   1'b1, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
        dir_row(sbl_pkg::CH_NINE,   1'b0, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
        dir_row(sbl_pkg::CH_RPAREN, 1'b0, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
        // octal
        dir_row(sbl_pkg::CH_ZERO,   1'b0, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
        dir_row(sbl_pkg::CH_SEVEN,  1'b0, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
        dir_row(sbl_pkg::CH_TAB,    1'b0, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
        // hex, mixed case
        dir_row(sbl_pkg::CH_ZERO,   1'b0, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
        dir_row(sbl_pkg::CH_UC_X,   1'b0, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
        dir_row(sbl_pkg::CH_LC_A,   1'b0, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
        dir_row(sbl_pkg::CH_UC_F,   1'b0, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
        dir_row(sbl_pkg::CH_CR,     1'b0, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
        // nul drops the rest of the line
        dir_row(sbl_pkg::CH_NUL,    1'b0, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
        dir_row(sbl_pkg::CH_LPAREN, 1'b0, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
        dir_row(sbl_pkg::CH_LF,     1'b0, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
        // nul ends an identifier
        dir_row(sbl_pkg::CH_LC_A,   1'b0, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);
        dir_row(sbl_pkg::CH_NUL,    1'b1, sbl_pkg::K_IDENT, 63'd0, sbl_pkg::CH_LC_A, 1'b1);
        dir_row(sbl_pkg::CH_LF,     1'b0, sbl_pkg::K_NUMBER, 63'd0, 8'd0, 1'b0);

        // reset
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].b, 1'b0, dir_rows[i].typed, dir_rows[i].want);

        // random text: mostly well-formed tokens, some noise and skipped lines
        while (items_sent < 325)
        begin
            pick = $urandom_range(PICK_OPEN, PICK_NOISE);
            if (pick == PICK_SKIP_OPEN)
                pick = PICK_WORD;
            send_token(pick);
            if ($urandom_range(0, 9) < 7)
                repeat ($urandom_range(1, 3)) send_byte(rand_ws());
        end

        // leave a random token open, end the stream, then requests after the end
        pick = $urandom_range(PICK_CLOSE, PICK_SKIP_OPEN);
        send_token(pick);
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
        repeat (4)
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
        byte_chan.valid <= 1'b0;

        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (errors == 0 && pending_tokens.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // token side: check each taken token, stall at random
    initial
    begin : token_sink
        int unsigned stall;
        token_t      got;
        token_t      want;
        stall            = 0;
        token_chan.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (token_chan.valid && token_chan.ready)
            begin
                got.kind         = token_chan.kind;
                got.number_value = token_chan.number_value;
                got.ident_char   = token_chan.ident_char;
                got.ident_end    = token_chan.ident_end;
                got.last         = token_chan.last;
                if (pending_tokens.size() == 0)
                begin
                    $error("unexpected token: kind %0d", got.kind);
                    errors++;
                end
                else
                begin
                    want = pending_tokens.pop_front();
                    if (got.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, got.kind);
                        errors++;
                    end
                    if (got.number_value !== want.number_value)
                    begin
                        $error("number_value: expected %0d, got %0d",
                               want.number_value, got.number_value);
                        errors++;
                    end
                    if (got.ident_char !== want.ident_char)
                    begin
                        $error("ident_char: expected %02h, got %02h",
                               want.ident_char, got.ident_char);
                        errors++;
                    end
                    if (got.ident_end !== want.ident_end)
                    begin
                        $error("ident_end: expected %0d, got %0d", want.ident_end, got.ident_end);
                        errors++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        errors++;
                    end
                end
            end
            if ($urandom_range(0, 79) == 0)
                snk_calm = !snk_calm;
            if (stall > 0)
            begin
                stall--;
                token_chan.ready <= 1'b0;
            end
            else
            begin
                token_chan.ready <= 1'b1;
                if (!snk_calm)
                    stall = pick_gap();
            end
        end
    end

    // run limit
    initial
    begin : watchdog
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: sexpr_byte_lexer_top.f
hdl/sbl_pkg.sv
hdl/sbl_byte_if.sv
hdl/sbl_token_if.sv
hdl/sbl_lexer.sv
hdl/sbl_outq.sv
hdl/sexpr_byte_lexer_top.sv
test/testbench.sv
